[rtl/core/b2da_pkg.sv]
// shared types and constants for the binary to decimal ascii converter
`default_nettype none

package b2da_pkg;

  // width of one packed decimal digit
  localparam int unsigned DigitBits = 4;

  // ascii code of the character zero, in the width of the digit output
  localparam logic [5:0] AsciiZero = 6'd48;

  // shift-add-3 correction: digits at or above five get three added before the shift
  localparam logic [DigitBits-1:0] AdjLimit = 4'd5;
  localparam logic [DigitBits-1:0] AdjAdd   = 4'd3;

  // converter sequencer states
  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_SHIFT,
    CONV_DONE
  } conv_state_e;

endpackage

`default_nettype wire

[rtl/core/b2da_dabble.sv]
// bit-serial binary to packed bcd converter (shift and add three)
`default_nettype none

module b2da_dabble
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned NumDigits  = 20
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [VALUE_BITS-1:0]           in_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [NumDigits*DigitBits-1:0]       out_bcd_o
);

  localparam int unsigned BcdBits = NumDigits * DigitBits;
  localparam int unsigned CntBits = $clog2(VALUE_BITS);

  conv_state_e               state_q, state_d;
  logic [VALUE_BITS-1:0]     bin_q, bin_d;
  logic [BcdBits-1:0]        bcd_q, bcd_d;
  logic [BcdBits-1:0]        bcd_adj;
  logic [CntBits-1:0]        cnt_q, cnt_d;
  logic                      last_bit;

  assign last_bit = (cnt_q == CntBits'(VALUE_BITS - 1));

  // digit correction, each digit on its own
  always_comb begin
    for (int unsigned i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitBits +: DigitBits] >= AdjLimit) begin
        bcd_adj[i*DigitBits +: DigitBits] = bcd_q[i*DigitBits +: DigitBits] + AdjAdd;
      end else begin
        bcd_adj[i*DigitBits +: DigitBits] = bcd_q[i*DigitBits +: DigitBits];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CONV_IDLE: begin
        if (in_valid_i) state_d = CONV_SHIFT;
      end
      CONV_SHIFT: begin
        if (last_bit) state_d = CONV_DONE;
      end
      CONV_DONE: begin
        if (out_ready_i) state_d = CONV_IDLE;
      end
      default: state_d = CONV_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    unique case (state_q)
      CONV_IDLE: begin
        in_ready_o = 1'b1;
        bin_d      = in_value_i;
        bcd_d      = '0;
        cnt_d      = '0;
      end
      CONV_SHIFT: begin
        bcd_d = {bcd_adj[BcdBits-2:0], bin_q[VALUE_BITS-1]};
        bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CntBits'(1);
      end
      CONV_DONE: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_bcd_o = bcd_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

[rtl/core/b2da_emit.sv]
// digit serialiser: drops leading zeros and sends ascii digits most significant first
`default_nettype none

module b2da_emit
  import b2da_pkg::*;
#(
  parameter int unsigned NumDigits = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [NumDigits*DigitBits-1:0] in_bcd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [5:0]                         out_char_o,
  output logic                               out_last_o
);

  localparam int unsigned BcdBits = NumDigits * DigitBits;
  localparam int unsigned RemBits = $clog2(NumDigits + 1);

  logic                  busy_q, busy_d;
  logic                  started_q, started_d;
  logic [RemBits-1:0]    rem_q, rem_d;
  logic [BcdBits-1:0]    bcd_q, bcd_d;
  logic [DigitBits-1:0]  top_digit;
  logic                  one_left;
  logic                  show;

  assign top_digit = bcd_q[BcdBits-1 -: DigitBits];
  assign one_left  = (rem_q == RemBits'(1));
  // a digit is shown once the first non-zero digit is reached, or for the units digit
  assign show      = (top_digit != '0) || started_q || one_left;

  assign in_ready_o  = !busy_q;
  assign out_valid_o = busy_q && show;
  assign out_char_o  = AsciiZero + {2'b00, top_digit};
  assign out_last_o  = one_left;

  // walk through the digits: skip leading zeros, then one digit per taken item
  always_comb begin
    busy_d    = busy_q;
    started_d = started_q;
    rem_d     = rem_q;
    bcd_d     = bcd_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d    = 1'b1;
        started_d = 1'b0;
        rem_d     = RemBits'(NumDigits);
        bcd_d     = in_bcd_i;
      end
    end else if (!show || out_ready_i) begin
      bcd_d = {bcd_q[BcdBits-DigitBits-1:0], {DigitBits{1'b0}}};
      rem_d = rem_q - RemBits'(1);
      if (show) started_d = 1'b1;
      if (show && one_left) busy_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      started_q <= 1'b0;
      rem_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      started_q <= started_d;
      rem_q     <= rem_d;
    end
  end

  // digit shift register
  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

[rtl/core/binary_to_decimal_ascii_top.sv]
// Top level of the binary to decimal ascii converter
// The first digit comes after the conversion, the hand-off and the skip of each leading zero
// digit (20 digit places at VALUE_BITS = 64).
// A new number is taken once the one-bit-per-cycle shift-add-3 loop, hand-off to a free emitter
// and reload end; digits leave meanwhile at one per cycle while the receiver is ready.
// Reset: rst_ni clears all control state at once; no clearing pass is needed.
`default_nettype none

module binary_to_decimal_ascii_top
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] value
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [5:0] digit_char, [7:6] zero
  output logic             m_axis_tlast_o    // last_digit
);

  // decimal places needed for 2^VALUE_BITS - 1 (1233/4096 approximates log10 of 2)
  localparam int unsigned NumDigits = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BcdBits   = NumDigits * DigitBits;

  logic               hand_valid;
  logic               hand_ready;
  logic [BcdBits-1:0] hand_bcd;
  logic [5:0]         digit_char;

  // bit-serial conversion
  b2da_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NumDigits  (NumDigits)
  ) u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i[VALUE_BITS-1:0]),
    .out_valid_o (hand_valid),
    .out_ready_i (hand_ready),
    .out_bcd_o   (hand_bcd)
  );

  // digit output
  b2da_emit #(
    .NumDigits (NumDigits)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hand_valid),
    .in_ready_o  (hand_ready),
    .in_bcd_i    (hand_bcd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (digit_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, digit_char};

endmodule

`default_nettype wire

[rtl/core/b2da_checker.sv]
// port-level checks for the binary to decimal ascii converter, with bind
`default_nettype none

module b2da_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  logic first_q;

  // marks the first digit of each number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      first_q <= m_axis_tlast_o;
    end
  end

  // a stalled digit holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // every digit is an ascii decimal character
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o >= 8'd48) && (m_axis_tdata_o <= 8'd57))
    else $error("digit outside 0 to 9");

  // no leading zero: a leading zero digit is only the whole number zero
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && first_q && (m_axis_tdata_o == 8'd48) |-> m_axis_tlast_o)
    else $error("leading zero digit");

  // the converter is busy for the cycle after taking a number
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken on consecutive cycles");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the binary to decimal ascii converter
`default_nettype none

module tb;
  import b2da_pkg::*;

  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned MaxDigits   = 20;
  localparam logic [63:0] ValueMask   = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned RandomItems = 320;
  localparam int unsigned FlatItems   = 70;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last_digit;
  } digit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata;    // [63:0] value
  logic        m_axis_tvalid_o;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata_o;  // [5:0] digit_char, [7:6] zero
  logic        m_axis_tlast_o;  // last_digit

  // expected characters, oldest first
  digit_t      pending_digits[$];
  digit_t      want;
  int unsigned numbers_sent;
  int unsigned digits_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int unsigned hold_request;

  binary_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // decimal digits of a number, most significant first, appended to the pending list
  function automatic void queue_decimal_digits(input logic [63:0] number);
    logic [63:0] rest;
    logic [3:0]  digs [MaxDigits];
    int          n;
    rest = number & ValueMask;
    n = 0;
    do begin
      digs[n] = 4'(rest % 64'd10);
      rest    = rest / 64'd10;
      n++;
    end while (rest != 64'd0 && n < MaxDigits);
    for (int k = n - 1; k >= 0; k--) begin
      pending_digits.push_back('{digit_char: AsciiZero + 6'(digs[k]), last_digit: (k == 0)});
    end
  endfunction

  // offer one number and wait until it is taken
  task automatic send_number(input logic [63:0] number);
    int unsigned gap;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    do @(posedge clk_i); while (!s_axis_tready_o);
    queue_decimal_digits(number);
    numbers_sent++;
  endtask

  // random number of random length, so that every digit count turns up
  function automatic logic [63:0] random_number();
    logic [63:0] full;
    full = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0:       return full;
      1:       return full >> $urandom_range(0, 63);
      2:       return full % 64'd1000;
      default: return full >> $urandom_range(40, 63);
    endcase
  endfunction

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request  = 0;
        m_axis_tready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each character leaving the block with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      digits_seen++;
      if (pending_digits.size() == 0) begin
        $error("digit_char: nothing expected, actual %0d", m_axis_tdata_o[5:0]);
        mismatches++;
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata_o[5:0] !== want.digit_char) begin
          $error("digit_char: expected %0d, actual %0d", want.digit_char, m_axis_tdata_o[5:0]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last_digit) begin
          $error("last_digit: expected %0d, actual %0d", want.last_digit, m_axis_tlast_o);
          mismatches++;
        end
        if (m_axis_tdata_o[7:6] !== 2'b00) begin
          $error("tdata padding: expected 0, actual %0d", m_axis_tdata_o[7:6]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("binary_to_decimal_ascii_top test failed");
        $finish;
      end
    end
  end

  // extremes, digit-count boundaries and bit patterns
  task automatic test_directed();
    logic [63:0] p10;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd99);
    send_number(64'd100);
    send_number(64'd999_999_999);
    send_number(64'd1_000_000_000);
    send_number(64'd999_999_999_999_999_999);
    send_number(64'd1_000_000_000_000_000_000);
    send_number(64'd9_999_999_999_999_999_999);
    send_number(64'd10_000_000_000_000_000_000);
    send_number(64'd12_345_678_901_234_567_890);
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    send_number(64'h5555_5555_5555_5555);
    send_number(64'hFFFF_FFFF_FFFF_FFFE);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    // powers of a thousand plus seven, with inner zeros, and gaps on the sink
    sink_stalls_on = 1'b1;
    p10 = 64'd1;
    for (int k = 0; k < 3; k++) begin
      p10 = p10 * 64'd1000;
      send_number(p10 + 64'd7);
    end
  endtask

  // random numbers with idling on both sides
  task automatic test_random();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (RandomItems) send_number(random_number());
  endtask

  // receiver holds off for a long stretch while numbers keep coming
  task automatic test_backpressure();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    hold_request   = HoldCycles;
    repeat (10) send_number({$urandom(), $urandom()});
    while (hold_request != 0) @(posedge clk_i);
  endtask

  // final stretch at full rate, no idling at all
  task automatic test_full_rate();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (FlatItems) send_number(random_number());
  endtask

  // stimulus and end of run
  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= 64'd0;
    numbers_sent   = 0;
    digits_seen    = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    hold_request   = 0;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();

    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (VALUE_BITS + 24) @(posedge clk_i);

    $display("converted %0d numbers into %0d digit characters", numbers_sent, digits_seen);
    $display("covered boundaries up to 20 digits, random idling and a long output hold-off");
    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii_top test passed");
    end else begin
      $display("binary_to_decimal_ascii_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/core/b2da_pkg.sv
rtl/core/b2da_dabble.sv
rtl/core/b2da_emit.sv
rtl/core/binary_to_decimal_ascii_top.sv
rtl/core/b2da_checker.sv
tb/tb.sv
